@@ sv/svl_pkg.sv @@
// shared types and request codes for the sorted value list
`default_nettype none

package svl_pkg;

  // value width and request codes
  localparam int VALUE_W = 32;
  localparam int REQ_W   = 2;
  localparam int COUNT_W = 5;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               capture;
    logic               ins_en;
    logic               rem_en;
    logic [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/svl_cell.sv @@
// one cell of the sorted chain: holds an entry and its compare flags
`default_nettype none

module svl_cell
  import svl_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cell_ctrl_t         ctrl,
  input  wire logic [CNT_W-1:0]   count,
  input  wire logic [VALUE_W-1:0] prev_entry,
  input  wire logic               prev_less,
  input  wire logic [VALUE_W-1:0] next_entry,
  output logic [VALUE_W-1:0]      entry,
  output logic                    less,
  output logic                    eq,
  output logic                    hit
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [VALUE_W-1:0] entry_r;
  logic               less_r;
  logic               eq_r;
  logic               occ;

  // cell holds a live entry when it lies below the count
  assign occ = IDX_C < count;

  // compare flags, captured when a word is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      less_r <= 1'b0;
      eq_r   <= 1'b0;
    end else if (ctrl.capture) begin
      less_r <= occ && ($signed(entry_r) < $signed(ctrl.value));
      eq_r   <= occ && (entry_r == ctrl.value);
    end
  end

  // shift towards the tail on insert, towards the head on remove
  always_ff @(posedge clk) begin
    if (ctrl.ins_en && !less_r) begin
      entry_r <= prev_less ? ctrl.value : prev_entry;
    end else if (ctrl.rem_en && !less_r) begin
      entry_r <= next_entry;
    end
  end

  assign entry = entry_r;
  assign less  = less_r;
  assign eq    = eq_r;
  // first cell not below the value, and equal to it
  assign hit   = !less_r && prev_less && eq_r;

endmodule

`default_nettype wire

@@ sv/svl_ctrl.sv @@
// handshake, entry count and result register for the sorted value list
`default_nettype none

module svl_ctrl
  import svl_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int CNT_W    = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [VALUE_W-1:0] in_value,
  input  wire logic [REQ_W-1:0]   in_req,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic                    out_ok,
  output logic [VALUE_W-1:0]      out_value,
  output logic [COUNT_W-1:0]      out_count,
  input  wire logic               hit_any,
  input  wire logic               eq_any,
  output cell_ctrl_t              ctrl,
  output logic [CNT_W-1:0]        count
);

  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);

  logic                 busy_r, busy_nxt;
  logic [REQ_W-1:0]     req_r;
  logic [VALUE_W-1:0]   val_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r;
  logic [VALUE_W-1:0]   out_value_r;
  logic [COUNT_W-1:0]   out_count_r;
  logic                 accept, apply, out_free;
  logic                 ins_ok, rem_ok, look_ok;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  // handshake: one word in flight, result slot drains as the next enters
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !busy_r && out_free;
  assign accept    = in_tvalid && in_tready;
  assign apply     = busy_r && out_free;

  // outcome of the pending request from the cell flags
  assign ins_ok  = (req_r == REQ_INSERT) && (count_r != FULL_C);
  assign rem_ok  = (req_r == REQ_REMOVE) && hit_any;
  assign look_ok = (req_r == REQ_LOOKUP) && eq_any;

  // broadcast to the cells
  always_comb begin
    ctrl.capture = accept;
    ctrl.ins_en  = apply && ins_ok;
    ctrl.rem_en  = apply && rem_ok;
    ctrl.value   = busy_r ? val_r : in_value;
  end

  // next count and control state
  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins_en) begin
      count_nxt = count_r + ONE_C;
    end else if (ctrl.rem_en) begin
      count_nxt = count_r - ONE_C;
    end
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (apply) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
      val_r <= in_value;
    end
    if (apply) begin
      out_ok_r    <= ins_ok || rem_ok || look_ok;
      out_value_r <= look_ok ? val_r : '0;
      out_count_r <= count_ext[COUNT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_ok     = out_ok_r;
  assign out_value  = out_value_r;
  assign out_count  = out_count_r;
  assign count      = count_r;

  // count stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_C)
    else $error("entry count beyond capacity");

  // a successful insert grows the count by one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins_en |=> count_r == $past(count_r) + ONE_C)
    else $error("insert did not grow the count");

  // a result appears only after a pending request
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r))
    else $error("result without a pending request");

  // no new word taken while one is pending
  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_tready)
    else $error("word accepted while busy");

endmodule

`default_nettype wire

@@ sv/sorted_value_list.sv @@
// top level of the sorted value list: controller and chain of cells
//
// Keeps an ascending list of signed 32-bit values, duplicates allowed, in a
// chain of CAPACITY cells. Each input word carries a request kind in in_tuser
// (insert, remove first match, look up) and the value in in_tdata. For every
// word one result word leaves on the out_ channel with the success flag in
// out_tuser and the looked-up value and entry count in out_tdata.
// The word is taken and every cell registers its compare flags against the
// value; then the cells shift in parallel and the result register loads.
// No new word is taken while one is pending; the next word can be taken in
// the cycle the result appears, when the receiver is ready. Each word passes
// the compare stage and then the shift stage.
// A stalled receiver holds the result register; the pending request waits
// and in_tready stays low until the result slot frees.
// Reset (rst_n low, synchronous) empties the list; entries need no clearing
// as only cells below the count are ever compared.
`default_nettype none

module sorted_value_list
  import svl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // value[31:0]
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // found_value[31:0], entry_count[36:32], zero pad
  output logic             out_tuser   // ok
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  cell_ctrl_t         ctrl;
  logic [CNT_W-1:0]   count;
  logic [VALUE_W-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0] less_w, eq_w, hit_w;
  logic               out_ok;
  logic [VALUE_W-1:0] out_value;
  logic [COUNT_W-1:0] out_count;

  svl_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_value   (in_tdata),
    .in_req     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_ok     (out_ok),
    .out_value  (out_value),
    .out_count  (out_count),
    .hit_any    (|hit_w),
    .eq_any     (|eq_w),
    .ctrl       (ctrl),
    .count      (count)
  );

  // chain of cells, head at index zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] prev_entry, next_entry;
    logic               prev_less;

    if (i == 0) begin : g_head
      assign prev_entry = ctrl.value;
      assign prev_less  = 1'b1;
    end else begin : g_mid
      assign prev_entry = entry_w[i-1];
      assign prev_less  = less_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = entry_w[i];
    end else begin : g_body
      assign next_entry = entry_w[i+1];
    end

    svl_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .count      (count),
      .prev_entry (prev_entry),
      .prev_less  (prev_less),
      .next_entry (next_entry),
      .entry      (entry_w[i]),
      .less       (less_w[i]),
      .eq         (eq_w[i]),
      .hit        (hit_w[i])
    );
  end

  // result word packing
  assign out_tdata = {3'b000, out_count, out_value};
  assign out_tuser = out_ok;

endmodule

`default_nettype wire

@@ test/tb_sorted_value_list.sv @@
// testbench for the sorted value list: directed and random requests checked against a local list
`default_nettype none

module tb_sorted_value_list
  import svl_pkg::*;
();

  localparam int LIST_DEPTH = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 80;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic               ok;
    logic [VALUE_W-1:0] found_value;
    logic [COUNT_W-1:0] entry_count;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // value[31:0]
  logic [1:0]  in_tuser;   // req_type[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // found_value[31:0], entry_count[36:32], zero pad
  logic        out_tuser;  // ok

  // local copy of the list and the results still owed by the block
  logic signed [VALUE_W-1:0] list_model [LIST_DEPTH];
  int                        list_len;
  list_result_t              pending_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_request;
  int hold_left;
  int quiet_cycles;
  int fail_count;

  sorted_value_list #(
    .CAPACITY(LIST_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one request to the local list and work out its result word
  function automatic list_result_t apply_request(logic [REQ_W-1:0] kind,
                                                 logic signed [VALUE_W-1:0] v);
    list_result_t r;
    int pos;
    int i;
    r.ok = 1'b0;
    r.found_value = '0;
    pos = 0;
    case (kind)
      REQ_INSERT: begin
        if (list_len < LIST_DEPTH) begin
          while (pos < list_len && list_model[pos] < v) pos++;
          for (i = list_len; i > pos; i--) list_model[i] = list_model[i-1];
          list_model[pos] = v;
          list_len++;
          r.ok = 1'b1;
        end
      end
      REQ_REMOVE: begin
        while (pos < list_len && list_model[pos] != v) pos++;
        if (pos < list_len) begin
          for (i = pos; i + 1 < list_len; i++) list_model[i] = list_model[i+1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      REQ_LOOKUP: begin
        for (i = 0; i < list_len; i++) begin
          if (list_model[i] == v) r.ok = 1'b1;
        end
        if (r.ok) r.found_value = v;
      end
      default: begin
        // unused code leaves the list alone
      end
    endcase
    r.entry_count = COUNT_W'(list_len);
    return r;
  endfunction

  // one word on the input side, with random gaps ahead of it
  task automatic send_request(logic [REQ_W-1:0] kind, logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_request(kind, v));
  endtask

  // stop offering and wait for every owed result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // value source: held entries for hits, a pool of corner values, or anything
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] pool [8];
    int sel;
    pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
             32'h1, 32'h5, 32'hffff_fffb, 32'h64};
    sel = $urandom_range(3);
    if (sel <= 1 && list_len > 0) return list_model[$urandom_range(list_len - 1)];
    if (sel == 2) return pool[$urandom_range(7)];
    return $urandom;
  endfunction

  // lookup and remove on an empty list
  task automatic test_empty_list();
    send_request(REQ_LOOKUP, 32'h0);
    send_request(REQ_REMOVE, 32'h0);
  endtask

  // extremes, duplicates, signed ordering, hits and misses
  task automatic test_extremes_and_order();
    send_request(REQ_INSERT, 32'h7fff_ffff);
    send_request(REQ_INSERT, 32'h8000_0000);
    send_request(REQ_INSERT, 32'h0);
    send_request(REQ_INSERT, 32'h0);
    send_request(REQ_INSERT, 32'hffff_ffff);
    send_request(REQ_LOOKUP, 32'h8000_0000);
    send_request(REQ_LOOKUP, 32'h7);
    send_request(REQ_REMOVE, 32'h0);
    send_request(REQ_REMOVE, 32'h7fff_ffff);
  endtask

  // fill to capacity, insert when full, unused code
  task automatic test_full_list();
    while (list_len < LIST_DEPTH) send_request(REQ_INSERT, $urandom);
    send_request(REQ_INSERT, 32'h7fff_ffff);
    send_request(REQ_UNUSED, 32'hffff_ffff);
  endtask

  // mixed traffic steering the count towards a target that moves
  task automatic test_random_traffic(int n);
    int target_len;
    int roll;
    logic [REQ_W-1:0] kind;
    target_len = 8;
    for (int k = 0; k < n; k++) begin
      if (k % 32 == 0) target_len = $urandom_range(LIST_DEPTH);
      roll = $urandom_range(99);
      if (roll < 4) kind = REQ_UNUSED;
      else if (roll < 24) kind = REQ_LOOKUP;
      else if (list_len < target_len) kind = (roll < 80) ? REQ_INSERT : REQ_REMOVE;
      else kind = (roll < 80) ? REQ_REMOVE : REQ_INSERT;
      send_request(kind, pick_value());
    end
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    int saved_pct;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    hold_request = HOLD_CYCLES;
    for (int k = 0; k < 12; k++) send_request(REQ_LOOKUP, pick_value());
    send_idle_pct = saved_pct;
    drain_results();
  endtask

  // receiver ready, with random stalls and the long hold-off
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checking against the oldest owed word
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result word: ok=%0b value=%h count=%0d",
                   out_tuser, out_tdata[31:0], out_tdata[36:32]);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.ok || out_tdata[31:0] !== want.found_value ||
            out_tdata[36:32] !== want.entry_count) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected ok=%0b value=%h count=%0d, got ok=%0b value=%h count=%0d",
                     want.ok, want.found_value, want.entry_count,
                     out_tuser, out_tdata[31:0], out_tdata[36:32]);
        end
      end
    end
  end

  // cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // test sequence
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = REQ_INSERT;
    out_tready = 1'b0;
    list_len = 0;
    hold_request = 0;
    hold_left = 0;
    quiet_cycles = 0;
    fail_count = 0;
    send_idle_pct = 35;
    recv_idle_pct = 65;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_extremes_and_order();
    test_full_list();
    test_random_traffic(440);
    drain_results();
    test_backpressure();

    send_idle_pct = 65;
    recv_idle_pct = 35;
    test_random_traffic(440);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(440);
    drain_results();

    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sorted_value_list.f @@
sv/svl_pkg.sv
sv/svl_cell.sv
sv/svl_ctrl.sv
sv/sorted_value_list.sv
test/tb_sorted_value_list.sv
